@@ rtl/min_heap_priority_queue_assert.svh @@
`ifndef MIN_HEAP_PRIORITY_QUEUE_ASSERT_SVH
`define MIN_HEAP_PRIORITY_QUEUE_ASSERT_SVH

// same-cycle property, clocked on clk, off during rst
`define MHPQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// next-cycle implication
`define MHPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/mhpq_pkg.sv @@
`default_nettype none

package mhpq_pkg;

  localparam int CAPACITY  = 1024;
  localparam int KEY_BITS  = 16;
  localparam int DATA_BITS = 32;
  localparam int ADDR_W    = $clog2(CAPACITY);
  localparam int CNT_W     = $clog2(CAPACITY + 1);

  typedef enum logic [0:0] {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    STATUS_DONE  = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP_CHK,
    S_UP_CMP,
    S_RM_ROOT,
    S_RM_LAST,
    S_DN_CHK,
    S_DN_CMP,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [KEY_BITS-1:0]  key;
    logic [DATA_BITS-1:0] data;
  } entry_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    entry_t            data;
  } wr_req_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr_a;
    logic [ADDR_W-1:0] addr_b;
  } rd_req_t;

endpackage

`default_nettype wire

@@ rtl/mhpq_store.sv @@
`default_nettype none

module mhpq_store
  import mhpq_pkg::*;
(
  input  wire logic    clk,
  input  wire wr_req_t wr,
  input  wire rd_req_t rd,
  output entry_t       rd_a,
  output entry_t       rd_b
);

  entry_t mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_a <= mem[rd.addr_a];
    rd_b <= mem[rd.addr_b];
  end

endmodule

`default_nettype wire

@@ rtl/min_heap_priority_queue.sv @@
// channel | valid    | stall     | fields
// --------+----------+-----------+-------------------------------------
// in      | in_valid | in_stall  | opcode, key, payload
// out     | out_valid| out_stall | status, out_key, out_payload, fill
//
// Insert climbs via S_UP_CHK/S_UP_CMP per level. Remove reads the root in
// S_RM_ROOT; unless it took the only pair, it reads the last pair in S_RM_LAST
// and descends via S_DN_CHK/S_DN_CMP per level. Remove on empty or insert on
// full goes straight to S_DONE. S_DONE returns to S_IDLE before the next transfer.
// Reset clears the fill count, state and out_valid; RAM contents are not cleared.
// Under out_stall the next operation is accepted and waits in its final state.
`default_nettype none

module min_heap_priority_queue
  import mhpq_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic                 opcode,
  input  wire logic [KEY_BITS-1:0]  key,
  input  wire logic [DATA_BITS-1:0] payload,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [1:0]                status,
  output logic [KEY_BITS-1:0]       out_key,
  output logic [DATA_BITS-1:0]      out_payload,
  output logic [CNT_W-1:0]          fill
);

  state_t               state, state_next;
  logic [CNT_W-1:0]     count, count_next;
  logic [ADDR_W-1:0]    pos, pos_next;
  entry_t               cur, cur_next;
  status_t              res_status, res_status_next;
  logic [KEY_BITS-1:0]  res_key, res_key_next;
  logic [DATA_BITS-1:0] res_data, res_data_next;

  wr_req_t              wr;
  rd_req_t              rd;
  entry_t               rd_a, rd_b;

  logic [ADDR_W-1:0]    parent;
  logic [ADDR_W:0]      lchild;
  logic [ADDR_W+1:0]    rchild;
  logic [CNT_W-1:0]     cnt_dec;
  logic                 l_in, r_in;
  entry_t               pick;
  logic [ADDR_W-1:0]    pick_addr;
  logic                 load;

  mhpq_store u_store (
    .clk  (clk),
    .wr   (wr),
    .rd   (rd),
    .rd_a (rd_a),
    .rd_b (rd_b)
  );

  assign parent  = (pos - ADDR_W'(1)) >> 1;
  assign lchild  = {pos, 1'b1};
  assign rchild  = {1'b0, lchild} + (ADDR_W+2)'(1);
  assign cnt_dec = count - CNT_W'(1);
  assign l_in    = {1'b0, lchild} < (ADDR_W+2)'(count);
  assign r_in    = rchild < (ADDR_W+2)'(count);

  // right child wins on equal keys
  always_comb begin
    if (r_in && !(rd_a.key < rd_b.key)) begin
      pick      = rd_b;
      pick_addr = rchild[ADDR_W-1:0];
    end else begin
      pick      = rd_a;
      pick_addr = lchild[ADDR_W-1:0];
    end
  end

  assign in_stall = (state != S_IDLE);
  assign load     = (state == S_DONE) && (!out_valid || !out_stall);

  always_comb begin
    state_next      = state;
    count_next      = count;
    pos_next        = pos;
    cur_next        = cur;
    res_status_next = res_status;
    res_key_next    = res_key;
    res_data_next   = res_data;
    wr.en           = 1'b0;
    wr.addr         = pos;
    wr.data         = cur;
    rd.addr_a       = lchild[ADDR_W-1:0];
    rd.addr_b       = rchild[ADDR_W-1:0];
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          res_status_next = STATUS_DONE;
          res_key_next    = '0;
          res_data_next   = '0;
          if (opcode == OP_INSERT) begin
            if (count == CNT_W'(CAPACITY)) begin
              res_status_next = STATUS_FULL;
              state_next      = S_DONE;
            end else begin
              cur_next.key  = key;
              cur_next.data = payload;
              pos_next      = count[ADDR_W-1:0];
              count_next    = count + CNT_W'(1);
              state_next    = S_UP_CHK;
            end
          end else begin
            if (count == '0) begin
              res_status_next = STATUS_EMPTY;
              state_next      = S_DONE;
            end else begin
              rd.addr_a  = '0;
              state_next = S_RM_ROOT;
            end
          end
        end
      end
      S_UP_CHK: begin
        if (pos == '0) begin
          wr.en      = 1'b1;
          state_next = S_DONE;
        end else begin
          rd.addr_a  = parent;
          state_next = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        wr.en = 1'b1;
        if (cur.key < rd_a.key) begin
          wr.data    = rd_a;
          pos_next   = parent;
          state_next = S_UP_CHK;
        end else begin
          state_next = S_DONE;
        end
      end
      S_RM_ROOT: begin
        res_key_next  = rd_a.key;
        res_data_next = rd_a.data;
        count_next    = cnt_dec;
        if (cnt_dec == '0) begin
          state_next = S_DONE;
        end else begin
          rd.addr_a  = cnt_dec[ADDR_W-1:0];
          state_next = S_RM_LAST;
        end
      end
      S_RM_LAST: begin
        cur_next   = rd_a;
        pos_next   = '0;
        state_next = S_DN_CHK;
      end
      S_DN_CHK: begin
        if (!l_in) begin
          wr.en      = 1'b1;
          state_next = S_DONE;
        end else begin
          state_next = S_DN_CMP;
        end
      end
      S_DN_CMP: begin
        wr.en = 1'b1;
        if (cur.key > pick.key) begin
          wr.data    = pick;
          pos_next   = pick_addr;
          state_next = S_DN_CHK;
        end else begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid || !out_stall) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    pos        <= pos_next;
    cur        <= cur_next;
    res_status <= res_status_next;
    res_key    <= res_key_next;
    res_data   <= res_data_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      status      <= res_status;
      out_key     <= res_key;
      out_payload <= res_data;
      fill        <= count;
    end
  end

endmodule

`default_nettype wire

@@ rtl/mhpq_checker.sv @@
`default_nettype none

`include "min_heap_priority_queue_assert.svh"

module mhpq_checker
  import mhpq_pkg::*;
(
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 in_valid,
  input wire logic                 in_stall,
  input wire logic                 out_valid,
  input wire logic                 out_stall,
  input wire logic [1:0]           status,
  input wire logic [KEY_BITS-1:0]  out_key,
  input wire logic [DATA_BITS-1:0] out_payload,
  input wire logic [CNT_W-1:0]     fill
);

  `MHPQ_ASSERT(a_fill_cap, out_valid |-> (fill <= CNT_W'(CAPACITY)), "fill above capacity")

  `MHPQ_ASSERT(a_empty_res, (out_valid && status == STATUS_EMPTY) |-> (fill == '0 && out_key == '0 && out_payload == '0), "empty remove result wrong")

  `MHPQ_ASSERT(a_full_res, (out_valid && status == STATUS_FULL) |-> (fill == CNT_W'(CAPACITY) && out_key == '0), "full insert result wrong")

  `MHPQ_ASSERT_NEXT(a_busy, in_valid && !in_stall, in_stall, "not busy after transfer")

  `MHPQ_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid && $stable(out_key) && $stable(out_payload) && $stable(fill) && $stable(status), "stalled result changed")

endmodule

bind min_heap_priority_queue mhpq_checker u_mhpq_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .status      (status),
  .out_key     (out_key),
  .out_payload (out_payload),
  .fill        (fill)
);

`default_nettype wire
